// ===== design/spp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the servo press positioner: field widths, register indexes,
// phase encoding and the shared configuration and result types.
// Used by every module of the block; depends on nothing.
package spp_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;
    localparam int CntW     = 16;
    localparam int PulseW   = 10;
    localparam int LedCntW  = 8;
    localparam int MsW      = 32;
    localparam int PhaseW   = 2;
    localparam int ResDepth = 3;
    localparam int ResPtrW  = 2;
    localparam int ResCntW  = 2;

    localparam logic [LedCntW-1:0] LedLast = LedCntW'(249);
    localparam logic [CntW-1:0]    CntMax  = {CntW{1'b1}};

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_EDGE = 1'b1;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SHORT_MIN     = 3'd0,
        CFG_LONG_MIN      = 3'd1,
        CFG_SHORT_TARGET  = 3'd2,
        CFG_LONG_TARGET   = 3'd3,
        CFG_HOME_PULSE    = 3'd4,
        CFG_STEP_INTERVAL = 3'd5,
        CFG_HOLD_TICKS    = 3'd6,
        CFG_DEBOUNCE_MS   = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_MOVE = 3'b010,
        PH_HOLD = 3'b100
    } phase_t;

    localparam logic [PhaseW-1:0] PHASE_CODE_IDLE = 2'd0;
    localparam logic [PhaseW-1:0] PHASE_CODE_MOVE = 2'd1;
    localparam logic [PhaseW-1:0] PHASE_CODE_HOLD = 2'd2;
    localparam logic [PhaseW-1:0] PHASE_CODE_NONE = 2'd3;

    typedef struct packed {
        logic [CntW-1:0]   short_min;
        logic [CntW-1:0]   long_min;
        logic [PulseW-1:0] short_target;
        logic [PulseW-1:0] long_target;
        logic [PulseW-1:0] home_pulse;
        logic [CntW-1:0]   step_interval;
        logic [CntW-1:0]   hold_ticks;
        logic [CntW-1:0]   debounce_ms;
    } cfg_t;

    typedef struct packed {
        logic              [PhaseW-1:0] phase_out;
        logic                           busy_res;
        logic                           led_green;
        logic                           led_red;
        logic              [PulseW-1:0] servo_pulse;
    } result_t;

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        sat_inc = (v == CntMax) ? v : v + CntW'(1);
    endfunction

    function automatic logic [PhaseW-1:0] phase_code(input phase_t p);
        logic [PhaseW-1:0] code;
        unique case (p)
            PH_IDLE: code = PHASE_CODE_IDLE;
            PH_MOVE: code = PHASE_CODE_MOVE;
            PH_HOLD: code = PHASE_CODE_HOLD;
            default: code = PHASE_CODE_NONE;
        endcase
        phase_code = code;
    endfunction

endpackage

// ===== design/spp_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file of the servo press positioner.
// Depends on spp_pkg for the register indexes and the cfg_t bundle.
module spp_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         we,
    input  logic [spp_pkg::CfgIdxW-1:0]  idx,
    input  logic [spp_pkg::CfgDataW-1:0] wdata,
    output spp_pkg::cfg_t                cfg
);
    import spp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            unique case (cfg_idx_t'(idx))
                CFG_SHORT_MIN:     cfg_next.short_min     = wdata;
                CFG_LONG_MIN:      cfg_next.long_min      = wdata;
                CFG_SHORT_TARGET:  cfg_next.short_target  = wdata[PulseW-1:0];
                CFG_LONG_TARGET:   cfg_next.long_target   = wdata[PulseW-1:0];
                CFG_HOME_PULSE:    cfg_next.home_pulse    = wdata[PulseW-1:0];
                CFG_STEP_INTERVAL: cfg_next.step_interval = wdata;
                CFG_HOLD_TICKS:    cfg_next.hold_ticks    = wdata;
                CFG_DEBOUNCE_MS:   cfg_next.debounce_ms   = wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_min     <= CntW'(100);
            cfg_reg.long_min      <= CntW'(1000);
            cfg_reg.short_target  <= PulseW'(100);
            cfg_reg.long_target   <= PulseW'(120);
            cfg_reg.home_pulse    <= PulseW'(50);
            cfg_reg.step_interval <= CntW'(85);
            cfg_reg.hold_ticks    <= CntW'(10000);
            cfg_reg.debounce_ms   <= CntW'(50);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/spp_ctrl.sv =====
`timescale 1ns / 1ps
// Input beat register and press, ramp and hold state of the positioner.
// Each registered beat updates the state and emits the new state as a
// result. Depends on spp_pkg.
module spp_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_load,
    input  logic             in_mode,
    input  logic             in_level,
    input  spp_pkg::cfg_t    cfg,
    output logic             stage_valid,
    output spp_pkg::result_t res
);
    import spp_pkg::*;

    logic in_v_reg;
    logic mode_reg;
    logic level_reg;

    phase_t             phase_reg,     phase_next;
    logic               tick_en_reg,   tick_en_next;
    logic               pressed_reg,   pressed_next;
    logic [CntW-1:0]    press_ms_reg,  press_ms_next;
    logic [CntW-1:0]    step_reg,      step_next;
    logic [CntW-1:0]    hold_reg,      hold_next;
    logic [LedCntW-1:0] led_cnt_reg,   led_cnt_next;
    logic [PulseW-1:0]  pulse_reg,     pulse_next;
    logic [PulseW-1:0]  goal_reg,      goal_next;
    logic               accept_reg,    accept_next;
    logic [MsW-1:0]     ms_reg,        ms_next;
    logic [MsW-1:0]     last_edge_reg, last_edge_next;
    logic [1:0]         led_reg,       led_next;

    logic [MsW-1:0]  since_edge;
    logic [CntW-1:0] step_inc;
    logic [CntW-1:0] hold_inc;

    assign since_edge = ms_reg - last_edge_reg;
    assign step_inc   = sat_inc(step_reg);
    assign hold_inc   = sat_inc(hold_reg);

    always_comb
    begin
        phase_next     = phase_reg;
        tick_en_next   = tick_en_reg;
        pressed_next   = pressed_reg;
        press_ms_next  = press_ms_reg;
        step_next      = step_reg;
        hold_next      = hold_reg;
        led_cnt_next   = led_cnt_reg;
        pulse_next     = pulse_reg;
        goal_next      = goal_reg;
        accept_next    = accept_reg;
        ms_next        = ms_reg;
        last_edge_next = last_edge_reg;
        led_next       = led_reg;
        if (in_v_reg && mode_reg == MODE_TICK)
        begin
            ms_next = ms_reg + MsW'(1);
            if (tick_en_reg)
            begin
                step_next = step_inc;
                if (pressed_reg)
                begin
                    press_ms_next = sat_inc(press_ms_reg);
                end
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        led_next = 2'b01;
                    end
                    PH_MOVE:
                    begin
                        led_cnt_next = (led_cnt_reg >= LedLast) ? '0
                                     : led_cnt_reg + LedCntW'(1);
                        if (step_inc >= cfg.step_interval)
                        begin
                            if (pulse_reg < goal_reg)
                            begin
                                pulse_next = pulse_reg + PulseW'(1);
                            end
                            else if (pulse_reg > goal_reg)
                            begin
                                pulse_next = pulse_reg - PulseW'(1);
                            end
                            else
                            begin
                                phase_next   = PH_HOLD;
                                accept_next  = 1'b1;
                                led_cnt_next = '0;
                            end
                            step_next = '0;
                            hold_next = '0;
                        end
                        if (led_cnt_next == '0)
                        begin
                            led_next = ~led_reg;
                        end
                    end
                    PH_HOLD:
                    begin
                        if (pulse_reg == cfg.home_pulse)
                        begin
                            phase_next = PH_IDLE;
                        end
                        hold_next = hold_inc;
                        if (hold_inc >= cfg.hold_ticks)
                        begin
                            goal_next   = cfg.home_pulse;
                            phase_next  = PH_MOVE;
                            accept_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
        else if (in_v_reg && accept_reg && since_edge >= {16'd0, cfg.debounce_ms})
        begin
            last_edge_next = ms_reg;
            if (level_reg)
            begin
                press_ms_next = '0;
                pressed_next  = 1'b1;
                tick_en_next  = 1'b1;
            end
            else
            begin
                pressed_next = 1'b0;
                if (press_ms_reg > cfg.short_min && press_ms_reg <= cfg.long_min)
                begin
                    step_next   = '0;
                    phase_next  = PH_MOVE;
                    goal_next   = cfg.short_target;
                    accept_next = 1'b0;
                end
                else if (press_ms_reg > cfg.long_min)
                begin
                    step_next   = '0;
                    phase_next  = PH_MOVE;
                    goal_next   = cfg.long_target;
                    accept_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg      <= 1'b0;
            phase_reg     <= PH_IDLE;
            tick_en_reg   <= 1'b0;
            pressed_reg   <= 1'b0;
            press_ms_reg  <= '0;
            step_reg      <= '0;
            hold_reg      <= '0;
            led_cnt_reg   <= '0;
            pulse_reg     <= '0;
            goal_reg      <= '0;
            accept_reg    <= 1'b1;
            ms_reg        <= '0;
            last_edge_reg <= '0;
            led_reg       <= 2'b00;
        end
        else
        begin
            in_v_reg      <= in_load;
            phase_reg     <= phase_next;
            tick_en_reg   <= tick_en_next;
            pressed_reg   <= pressed_next;
            press_ms_reg  <= press_ms_next;
            step_reg      <= step_next;
            hold_reg      <= hold_next;
            led_cnt_reg   <= led_cnt_next;
            pulse_reg     <= pulse_next;
            goal_reg      <= goal_next;
            accept_reg    <= accept_next;
            ms_reg        <= ms_next;
            last_edge_reg <= last_edge_next;
            led_reg       <= led_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            mode_reg  <= in_mode;
            level_reg <= in_level;
        end
    end

    assign stage_valid     = in_v_reg;
    assign res.servo_pulse = pulse_next;
    assign res.led_red     = led_next[0];
    assign res.led_green   = led_next[1];
    assign res.busy_res    = ~accept_next;
    assign res.phase_out   = phase_code(phase_next);

endmodule

// ===== design/spp_res_fifo.sv =====
`timescale 1ns / 1ps
// Small result queue of the positioner: holds finished results until the
// output side takes them. Depends on spp_pkg for result_t and its depth.
module spp_res_fifo
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  spp_pkg::result_t            wr_data,
    input  logic                        pop,
    output logic                        not_empty,
    output logic [spp_pkg::ResCntW-1:0] count,
    output spp_pkg::result_t            rd_data
);
    import spp_pkg::*;

    localparam logic [ResPtrW-1:0] PtrLast = ResPtrW'(ResDepth - 1);

    result_t mem [ResDepth];

    logic [ResPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ResPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ResCntW-1:0] cnt_reg,    cnt_next;
    logic               do_pop;

    assign do_pop = pop && (cnt_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + ResPtrW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + ResPtrW'(1);
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + ResCntW'(1);
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - ResCntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data   = mem[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign count     = cnt_reg;

endmodule

// ===== design/servo_press_positioner_core.sv =====
`timescale 1ns / 1ps
// Top level of the servo press positioner: configuration registers, state
// update stage and result queue. Depends on spp_pkg, spp_cfg_regs,
// spp_ctrl and spp_res_fifo.
//
//   Channel   Direction  Content
//   s_axis    in         tick or button edge beat
//   m_axis    out        servo pulse, LEDs, busy and phase after each beat
//   cfg       in         register write, index and 16-bit data
//
// A beat is registered on acceptance. The registered beat then updates the
// state and is queued as a result at the same edge, and the queued result
// is offered on m_axis and taken when m_axis_tready is high.
// One beat is taken every cycle while the three-entry result queue has room
// for all beats in flight; a stalled output side fills it and then holds
// off the input. Reset clears control and queue state, loads register defaults.
module servo_press_positioner_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] button_level
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] servo_pulse, [10] led_red,
                                        // [11] led_green, [12] busy_res,
                                        // [14:13] phase_out
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import spp_pkg::*;

    localparam logic [ResCntW:0] InFlightMax = (ResCntW + 1)'(ResDepth);

    cfg_t               cfg;
    result_t            res_new;
    result_t            res_out;
    logic               stage_valid;
    logic               in_load;
    logic               q_not_empty;
    logic [ResCntW-1:0] q_count;
    logic [ResCntW:0]   in_flight;

    assign in_flight     = {1'b0, q_count} + {{ResCntW{1'b0}}, stage_valid};
    assign s_axis_tready = (in_flight < InFlightMax);
    assign in_load       = s_axis_tvalid && s_axis_tready;

    spp_cfg_regs u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .idx   (cfg_addr),
        .wdata (cfg_wdata),
        .cfg   (cfg)
    );

    spp_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_load     (in_load),
        .in_mode     (s_axis_tuser),
        .in_level    (s_axis_tdata[0]),
        .cfg         (cfg),
        .stage_valid (stage_valid),
        .res         (res_new)
    );

    spp_res_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (stage_valid),
        .wr_data   (res_new),
        .pop       (m_axis_tready),
        .not_empty (q_not_empty),
        .count     (q_count),
        .rd_data   (res_out)
    );

    assign m_axis_tvalid = q_not_empty;
    assign m_axis_tdata  = {1'b0, res_out};

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for servo_press_positioner_core: queued tick and
// button-edge beats are driven in phases of register settings and idling,
// and every output beat is checked against a cycle-free predictor. Uses spp_pkg.
module tb;
    import spp_pkg::*;

    localparam int CycleLimit = 300000;
    localparam int RxHoldLen  = 300;
    localparam int MaxReports = 50;

    typedef struct packed {
        logic       mode;
        logic [7:0] data;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = 3'd0;
    logic [15:0] cfg_wdata = 16'd0;

    beat_t   beat_q[$];
    result_t want_q[$];
    int      queued;
    int      errors;
    int      cycles;
    int      tx_idle_pct;
    int      rx_idle_pct;
    logic    rx_hold_req = 1'b0;
    int      rx_hold_cnt;
    logic [15:0] reg_vals [8];

    cfg_t              regs;
    logic [PhaseW-1:0] ph;
    logic              tick_en;
    logic              pressed_q;
    logic [CntW-1:0]   press_cnt;
    logic [CntW-1:0]   step_cnt;
    logic [CntW-1:0]   hold_cnt;
    logic [LedCntW-1:0] led_cnt;
    logic [PulseW-1:0] pulse_now;
    logic [PulseW-1:0] pulse_goal;
    logic              accepting;
    logic [MsW-1:0]    ms_clk;
    logic [MsW-1:0]    last_edge;
    logic [1:0]        leds;

    servo_press_positioner_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [CntW-1:0] bump16(input logic [CntW-1:0] v);
        return (v == CntMax) ? v : v + CntW'(1);
    endfunction

    function automatic void begin_move(input logic [PulseW-1:0] goal);
        step_cnt   = '0;
        ph         = PHASE_CODE_MOVE;
        pulse_goal = goal;
        accepting  = 1'b0;
    endfunction

    function automatic result_t servo_next(input logic mode, input logic level);
        result_t r;
        if (mode == MODE_TICK)
        begin
            ms_clk = ms_clk + MsW'(1);
            if (tick_en)
            begin
                step_cnt = bump16(step_cnt);
                if (pressed_q)
                    press_cnt = bump16(press_cnt);
                case (ph)
                    PHASE_CODE_IDLE: leds = 2'b01;
                    PHASE_CODE_MOVE:
                    begin
                        led_cnt = (led_cnt == LedLast) ? '0 : led_cnt + LedCntW'(1);
                        if (step_cnt >= regs.step_interval)
                        begin
                            if (pulse_now < pulse_goal)
                                pulse_now = pulse_now + PulseW'(1);
                            else if (pulse_now > pulse_goal)
                                pulse_now = pulse_now - PulseW'(1);
                            else
                            begin
                                ph        = PHASE_CODE_HOLD;
                                accepting = 1'b1;
                                led_cnt   = '0;
                            end
                            step_cnt = '0;
                            hold_cnt = '0;
                        end
                        if (led_cnt == '0)
                            leds = leds ^ 2'b11;
                    end
                    PHASE_CODE_HOLD:
                    begin
                        if (pulse_now == regs.home_pulse)
                            ph = PHASE_CODE_IDLE;
                        hold_cnt = bump16(hold_cnt);
                        if (hold_cnt >= regs.hold_ticks)
                        begin
                            pulse_goal = regs.home_pulse;
                            ph         = PHASE_CODE_MOVE;
                            accepting  = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
        else if (accepting && (ms_clk - last_edge) >= MsW'(regs.debounce_ms))
        begin
            last_edge = ms_clk;
            if (level)
            begin
                press_cnt = '0;
                pressed_q = 1'b1;
                tick_en   = 1'b1;
            end
            else
            begin
                pressed_q = 1'b0;
                if (press_cnt > regs.short_min && press_cnt <= regs.long_min)
                    begin_move(regs.short_target);
                else if (press_cnt > regs.long_min)
                    begin_move(regs.long_target);
            end
        end
        r.servo_pulse = pulse_now;
        r.led_red     = leds[0];
        r.led_green   = leds[1];
        r.busy_res    = ~accepting;
        r.phase_out   = ph;
        return r;
    endfunction

    task automatic push_beat(input logic mode, input logic level);
        beat_t b;
        b.mode = mode;
        b.data = {7'($urandom), level};
        beat_q.push_back(b);
        queued++;
    endtask

    task automatic queue_ticks(input int n);
        for (int i = 0; i < n; i++)
            push_beat(MODE_TICK, 1'($urandom));
    endtask

    task automatic queue_press(input int dur, input int tail);
        push_beat(MODE_EDGE, 1'b1);
        queue_ticks(dur);
        push_beat(MODE_EDGE, 1'b0);
        queue_ticks(tail);
    endtask

    task automatic queue_random(input int n);
        int base;
        int pick;
        int hi;
        base = queued;
        while (queued - base < n)
        begin
            pick = $urandom_range(99);
            hi = int'(regs.long_min) + 3;
            if (hi > 40)
                hi = 40;
            if (pick < 70)
                queue_press($urandom_range(hi), $urandom_range(90));
            else if (pick < 82)
                push_beat(MODE_EDGE, 1'($urandom_range(1)));
            else if (pick < 92)
                queue_ticks($urandom_range(20, 1));
            else
            begin
                push_beat(MODE_EDGE, 1'b1);
                queue_ticks($urandom_range(5));
                push_beat(MODE_EDGE, 1'b1);
                queue_ticks($urandom_range(hi));
            end
        end
    endtask

    task automatic load_regs();
        logic [15:0] v;
        for (int i = 0; i < 8; i++)
        begin
            v = reg_vals[i];
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_addr  <= 3'(i);
            cfg_wdata <= v;
            case (cfg_idx_t'(i))
                CFG_SHORT_MIN:     regs.short_min     = v;
                CFG_LONG_MIN:      regs.long_min      = v;
                CFG_SHORT_TARGET:  regs.short_target  = v[PulseW-1:0];
                CFG_LONG_TARGET:   regs.long_target   = v[PulseW-1:0];
                CFG_HOME_PULSE:    regs.home_pulse    = v[PulseW-1:0];
                CFG_STEP_INTERVAL: regs.step_interval = v;
                CFG_HOLD_TICKS:    regs.hold_ticks    = v;
                CFG_DEBOUNCE_MS:   regs.debounce_ms   = v;
                default: ;
            endcase
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic pick_random_regs();
        reg_vals[CFG_SHORT_MIN]     = 16'($urandom_range(6));
        reg_vals[CFG_LONG_MIN]      = 16'($urandom_range(14));
        reg_vals[CFG_SHORT_TARGET]  = {6'($urandom), 10'($urandom_range(30, 18))};
        reg_vals[CFG_LONG_TARGET]   = {6'($urandom), 10'($urandom_range(30, 18))};
        reg_vals[CFG_HOME_PULSE]    = {6'($urandom), 10'($urandom_range(30, 18))};
        reg_vals[CFG_STEP_INTERVAL] = 16'($urandom_range(3));
        reg_vals[CFG_HOLD_TICKS]    = 16'($urandom_range(25));
        reg_vals[CFG_DEBOUNCE_MS]   = 16'($urandom_range(4));
        load_regs();
    endtask

    task automatic wait_idle(input int extra);
        while (beat_q.size() != 0 || s_axis_tvalid || want_q.size() != 0)
            @(negedge clk);
        repeat (extra) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : drive
        beat_t nb;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                want_q.push_back(servo_next(s_axis_tuser, s_axis_tdata[0]));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (beat_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    nb = beat_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= nb.mode;
                    s_axis_tdata  <= nb.data;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rx_hold_req && rx_hold_cnt < RxHoldLen)
        begin
            rx_hold_cnt   <= rx_hold_cnt + 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            if (errors <= MaxReports)
                $display("%0t %s mismatch: expected %0d actual %0d",
                         $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata[14:0]);
            if (want_q.size() == 0)
            begin
                errors++;
                if (errors <= MaxReports)
                    $display("%0t unexpected beat: expected none actual %h",
                             $time, m_axis_tdata);
            end
            else
            begin
                want = want_q.pop_front();
                check_field("servo_pulse", int'(want.servo_pulse),
                            int'(got.servo_pulse));
                check_field("led_red", int'(want.led_red), int'(got.led_red));
                check_field("led_green", int'(want.led_green), int'(got.led_green));
                check_field("busy_res", int'(want.busy_res), int'(got.busy_res));
                check_field("phase_out", int'(want.phase_out), int'(got.phase_out));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        regs.short_min     = 16'd100;
        regs.long_min      = 16'd1000;
        regs.short_target  = 10'd100;
        regs.long_target   = 10'd120;
        regs.home_pulse    = 10'd50;
        regs.step_interval = 16'd85;
        regs.hold_ticks    = 16'd10000;
        regs.debounce_ms   = 16'd50;
        ph         = PHASE_CODE_IDLE;
        tick_en    = 1'b0;
        pressed_q  = 1'b0;
        press_cnt  = '0;
        step_cnt   = '0;
        hold_cnt   = '0;
        led_cnt    = '0;
        pulse_now  = '0;
        pulse_goal = '0;
        accepting  = 1'b1;
        ms_clk     = '0;
        last_edge  = '0;
        leds       = 2'b00;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Edges right after reset fall inside the default debounce window.
        push_beat(MODE_EDGE, 1'b0);
        push_beat(MODE_EDGE, 1'b1);
        queue_ticks(2);
        wait_idle(4);

        reg_vals[CFG_SHORT_MIN]     = 16'd2;
        reg_vals[CFG_LONG_MIN]      = 16'd5;
        reg_vals[CFG_SHORT_TARGET]  = 16'd5;
        reg_vals[CFG_LONG_TARGET]   = 16'd1;
        reg_vals[CFG_HOME_PULSE]    = 16'd3;
        reg_vals[CFG_STEP_INTERVAL] = 16'd1;
        reg_vals[CFG_HOLD_TICKS]    = 16'd2;
        reg_vals[CFG_DEBOUNCE_MS]   = 16'd0;
        load_regs();
        // A release with no press first, then a short press whose stale
        // duration is judged again by a later lone release.
        push_beat(MODE_EDGE, 1'b0);
        queue_press(3, 0);
        push_beat(MODE_EDGE, 1'b1);
        queue_ticks(14);
        push_beat(MODE_EDGE, 1'b0);
        queue_ticks(3);
        wait_idle(4);

        // Zero thresholds and intervals; short_min is not below long_min.
        for (int i = 0; i < 8; i++)
            reg_vals[i] = 16'h0000;
        load_regs();
        queue_random(80);
        wait_idle(4);

        for (int i = 0; i < 8; i++)
            reg_vals[i] = 16'hFFFF;
        load_regs();
        queue_random(60);
        wait_idle(4);

        pick_random_regs();
        rx_hold_req <= 1'b1;
        queue_random(110);
        wait_idle(4);
        queue_random(110);
        wait_idle(4);

        pick_random_regs();
        tx_idle_pct <= 79;
        queue_random(180);
        wait_idle(4);

        pick_random_regs();
        tx_idle_pct <= 0;
        rx_idle_pct <= 79;
        queue_random(180);
        wait_idle(4);

        pick_random_regs();
        tx_idle_pct <= 33;
        rx_idle_pct <= 33;
        queue_random(180);
        wait_idle(10);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
